@@ sv/bmp_rle_decoder_macros.svh @@
// Assertion macros used by the RTL of the BMP run-length decoder.
`ifndef BMP_RLE_DECODER_MACROS_SVH
`define BMP_RLE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define BRD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BRD_ASSERT_IMPLY(label, ante, cons, msg)
`define BRD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/bmprle_pkg.sv @@
// Shared widths, register indexes and types of the BMP run-length decoder.
package bmprle_pkg;

  localparam int unsigned DIM_FIELD_W = 14;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_ROWS_UP      = 3'd2;
  localparam cfg_idx_t REG_NIBBLE_MODE  = 3'd3;
  localparam cfg_idx_t REG_START_ODD    = 3'd4;

  typedef logic [DIM_FIELD_W-1:0] dim_field_t;
  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [COLOR_W-1:0]     color_t;

  // Status of a run on its way from the parser to the result register.
  typedef struct packed {
    logic err;
    logic done;
    logic even_ok;
    logic odd_ok;
  } run_flags_t;

endpackage

@@ sv/bmprle_if.sv @@
// Request channels of the BMP run-length decoder: input bytes and output runs.
interface bmprle_in_if;
  import bmprle_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  byte_t  data_byte;
  byte_t  palette_index;
  color_t palette_color;

  modport source (output valid, output action, output data_byte,
                  output palette_index, output palette_color, input ready);
  modport sink   (input valid, input action, input data_byte,
                  input palette_index, input palette_color, output ready);
endinterface

interface bmprle_out_if;
  import bmprle_pkg::*;

  logic       valid;
  logic       ready;
  dim_field_t pixel_row;
  dim_field_t pixel_col;
  byte_t      run_length;
  color_t     color_even;
  color_t     color_odd;
  logic       out_of_range;
  logic       bitmap_done;

  modport source (output valid, output pixel_row, output pixel_col, output run_length,
                  output color_even, output color_odd, output out_of_range,
                  output bitmap_done, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, input run_length,
                  input color_even, input color_odd, input out_of_range,
                  input bitmap_done, output ready);
endinterface

@@ sv/bmp_rle_decoder.sv @@
// Top level of the BMP RLE8 / RLE4 run decoder with its palette store.
//
//  Channel  | Direction | Handshake        | Carries
//  ---------+-----------+------------------+---------------------------------------
//  in_ch    | sink      | valid / ready    | data byte or palette entry write
//  out_ch   | source    | valid / ready    | one pixel run, end of bitmap, error
//  cfg_*    | write     | cfg_we only      | image size, row order, mode, parity
//
// One request is taken per cycle while in_ch ready is high. A data byte updates
// the parser and reads the palette at its accept edge; the run is then held in
// the run stage (s1) and moves on to the result register once that is free.
// The palette reads are registered in a single read stage alongside s1.
// A stall on out_ch holds the run stage and then drops in_ch ready.
// Reset (synchronous, rst_n low) clears control state; the palette stays
// undefined until written and needs no clearing pass.
`include "bmp_rle_decoder_macros.svh"

module bmp_rle_decoder #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned MAX_DIM       = 16384
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bmprle_in_if.sink                        in_ch,
  bmprle_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  bmprle_pkg::cfg_idx_t             cfg_index,
  input  logic [bmprle_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bmprle_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = (DIM_W > DIM_FIELD_W) ? DIM_W : DIM_FIELD_W;
  localparam int unsigned PAL_W = $clog2(PALETTE_DEPTH);

  // Parser phases
  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_INDEX = 3'd1;
  localparam logic [2:0] PH_ESC   = 3'd2;
  localparam logic [2:0] PH_DX    = 3'd3;
  localparam logic [2:0] PH_DY    = 3'd4;
  localparam logic [2:0] PH_ABS   = 3'd5;
  localparam logic [2:0] PH_PAD   = 3'd6;
  localparam logic [2:0] PH_HALT  = 3'd7;

  // Escape codes after a zero count byte
  localparam byte_t ESC_EOL   = 8'd0;
  localparam byte_t ESC_EOB   = 8'd1;
  localparam byte_t ESC_DELTA = 8'd2;

  // Add an 8-bit step to a position and saturate at the last coordinate.
  function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a, input byte_t b);
    logic [DIM_W:0] s;
    s = {1'b0, a} + (DIM_W + 1)'(b);
    if (s > (DIM_W + 1)'(MAX_DIM - 1)) begin
      return DIM_W'(MAX_DIM - 1);
    end
    return s[DIM_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  dim_field_t width_r, height_r;
  logic       rows_up_r, nibble_r, start_odd_r;
  logic       cfg_hit;

  always_comb begin
    case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_ROWS_UP,
      REG_NIBBLE_MODE, REG_START_ODD: cfg_hit = cfg_we;
      default:                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_FIELD_W'(1);
      height_r    <= DIM_FIELD_W'(1);
      rows_up_r   <= 1'b1;
      nibble_r    <= 1'b0;
      start_odd_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r     <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r    <= cfg_wdata;
        REG_ROWS_UP:      rows_up_r   <= cfg_wdata[0];
        REG_NIBBLE_MODE:  nibble_r    <= cfg_wdata[0];
        REG_START_ODD:    start_odd_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: run stage (s1) feeds the result register (out)
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s1_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic out_free, s1_adv, in_rdy, in_acc, data_acc;

  assign out_free = !out_vld_r || out_ch.ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_rdy   = !s1_vld_r || out_free;
  assign in_acc   = in_ch.valid && in_rdy;
  assign data_acc = in_acc && !in_ch.action;
  assign in_ch.ready = in_rdy;

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  logic [2:0]       phase_r, phase_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  byte_t            held_r, held_nxt;
  byte_t            dcol_r, dcol_nxt;
  logic             parity_r, parity_nxt;

  // Run clipping against the image bound, for the count the current phase emits
  byte_t            abs_n, run_count, run_len;
  logic             in_bounds, run_err, run_emit, run_done;
  logic [CMP_W-1:0] avail;
  logic [DIM_W-1:0] col_after;
  byte_t            held_dec;

  assign abs_n     = nibble_r ? ((held_r < 8'd2) ? held_r : 8'd2) : 8'd1;
  assign run_count = (phase_r == PH_ABS) ? abs_n : held_r;
  assign held_dec  = held_r - abs_n;
  assign in_bounds = (CMP_W'(row_r) < CMP_W'(height_r)) && (CMP_W'(col_r) < CMP_W'(width_r));
  assign avail     = CMP_W'(width_r) - CMP_W'(col_r);

  always_comb begin
    run_len = 8'd0;
    if (in_bounds) begin
      run_len = (CMP_W'(run_count) < avail) ? run_count : avail[BYTE_W-1:0];
    end
  end

  assign run_err   = run_len < run_count;
  assign col_after = sat_add(col_r, run_len);

  always_comb begin
    phase_nxt  = phase_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    held_nxt   = held_r;
    dcol_nxt   = dcol_r;
    parity_nxt = parity_r;
    run_emit   = 1'b0;
    run_done   = 1'b0;
    if (cfg_hit) begin
      // Restart decoding; the parity follows a start-offset write at once
      phase_nxt  = PH_COUNT;
      row_nxt    = '0;
      col_nxt    = '0;
      held_nxt   = '0;
      dcol_nxt   = '0;
      parity_nxt = (cfg_index == REG_START_ODD) ? cfg_wdata[0] : start_odd_r;
    end else if (data_acc) begin
      parity_nxt = !parity_r;
      case (phase_r)
        PH_COUNT: begin
          if (in_ch.data_byte == 8'd0) begin
            phase_nxt = PH_ESC;
          end else begin
            held_nxt  = in_ch.data_byte;
            phase_nxt = PH_INDEX;
          end
        end
        PH_INDEX: begin
          run_emit  = 1'b1;
          col_nxt   = col_after;
          phase_nxt = run_err ? PH_HALT : PH_COUNT;
        end
        PH_ESC: begin
          case (in_ch.data_byte)
            ESC_EOL: begin
              col_nxt   = '0;
              row_nxt   = sat_add(row_r, 8'd1);
              phase_nxt = PH_COUNT;
            end
            ESC_EOB: begin
              run_emit  = 1'b1;
              run_done  = 1'b1;
              phase_nxt = PH_HALT;
            end
            ESC_DELTA: phase_nxt = PH_DX;
            default: begin
              held_nxt  = in_ch.data_byte;
              phase_nxt = PH_ABS;
            end
          endcase
        end
        PH_DX: begin
          dcol_nxt  = in_ch.data_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          col_nxt   = sat_add(col_r, dcol_r);
          row_nxt   = sat_add(row_r, in_ch.data_byte);
          phase_nxt = PH_COUNT;
        end
        PH_ABS: begin
          run_emit = 1'b1;
          held_nxt = held_dec;
          col_nxt  = col_after;
          if (held_dec == 8'd0) begin
            // Skip a pad byte when the next byte would sit at an odd offset
            phase_nxt = !parity_r ? PH_PAD : PH_COUNT;
          end
          if (run_err) begin
            phase_nxt = PH_HALT;
          end
        end
        PH_PAD:  phase_nxt = PH_COUNT;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      row_r    <= '0;
      col_r    <= '0;
      held_r   <= '0;
      dcol_r   <= '0;
      parity_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      held_r   <= held_nxt;
      dcol_r   <= dcol_nxt;
      parity_r <= parity_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Palette store: a write on a palette request and two registered reads per accepted request
  // ---------------------------------------------------------------------------
  color_t           pal_mem [PALETTE_DEPTH];
  color_t           rd_even_r, rd_odd_r;
  logic [PAL_W-1:0] addr_even, addr_odd;
  byte_t            idx_even, idx_odd;
  logic             wr_ok;

  // RLE4 takes the high nibble for even offsets and the low nibble for odd
  assign idx_even  = nibble_r ? {4'd0, in_ch.data_byte[7:4]} : in_ch.data_byte;
  assign idx_odd   = nibble_r ? {4'd0, in_ch.data_byte[3:0]} : in_ch.data_byte;
  assign addr_even = PAL_W'(idx_even);
  assign addr_odd  = PAL_W'(idx_odd);
  assign wr_ok     = (9'(in_ch.palette_index) < 9'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_ch.action && wr_ok) begin
        pal_mem[PAL_W'(in_ch.palette_index)] <= in_ch.palette_color;
      end
      rd_even_r <= pal_mem[addr_even];
      rd_odd_r  <= pal_mem[addr_odd];
    end
  end

  // ---------------------------------------------------------------------------
  // Run stage
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] s1_row_r, s1_col_r;
  byte_t            s1_len_r;
  run_flags_t       s1_flags_r, s1_flags_nxt;

  assign s1_flags_nxt.err     = run_err && !run_done;
  assign s1_flags_nxt.done    = run_done;
  assign s1_flags_nxt.even_ok = (9'(idx_even) < 9'(PALETTE_DEPTH));
  assign s1_flags_nxt.odd_ok  = (9'(idx_odd) < 9'(PALETTE_DEPTH));

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = run_emit;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_len_r   <= run_done ? 8'd0 : run_len;
      s1_flags_r <= s1_flags_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: row flip and colour selection
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] row_ext, row_flip;
  dim_field_t       row_out;
  color_t           ce_out, co_out;

  assign row_ext  = CMP_W'(s1_row_r);
  assign row_flip = CMP_W'(height_r) - CMP_W'(1) - row_ext;
  assign row_out  = (rows_up_r && (row_ext < CMP_W'(height_r))) ?
                    row_flip[DIM_FIELD_W-1:0] : row_ext[DIM_FIELD_W-1:0];
  assign ce_out   = ((s1_len_r != 8'd0) && s1_flags_r.even_ok) ? rd_even_r : '0;
  assign co_out   = ((s1_len_r != 8'd0) && s1_flags_r.odd_ok) ? rd_odd_r : '0;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  dim_field_t o_row_r, o_col_r;
  byte_t      o_len_r;
  color_t     o_ce_r, o_co_r;
  logic       o_err_r, o_done_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_row_r  <= row_out;
      o_col_r  <= DIM_FIELD_W'(s1_col_r);
      o_len_r  <= s1_len_r;
      o_ce_r   <= ce_out;
      o_co_r   <= co_out;
      o_err_r  <= s1_flags_r.err;
      o_done_r <= s1_flags_r.done;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.pixel_row    = o_row_r;
  assign out_ch.pixel_col    = o_col_r;
  assign out_ch.run_length   = o_len_r;
  assign out_ch.color_even   = o_ce_r;
  assign out_ch.color_odd    = o_co_r;
  assign out_ch.out_of_range = o_err_r;
  assign out_ch.bitmap_done  = o_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BRD_ASSERT_IMPLY(a_stall_blocks_input, s1_vld_r && !out_free, !in_ch.ready, "input in stall")
  `BRD_ASSERT_NEXT(a_halt_holds, (phase_r == PH_HALT) && !cfg_we, phase_r == PH_HALT, "halt left")
  `BRD_ASSERT_NEXT(a_palette_no_run, in_acc && in_ch.action, !s1_vld_r, "palette write ran")

endmodule
